FILE: sv/ibsl_pkg.sv
// ----------------------------------------------------------------------------
// ibsl_pkg
// Shared types, constants and the control program for the bias, scale and
// low-pass block.
// ----------------------------------------------------------------------------
`default_nettype none

package ibsl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_BIAS_PITCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_BIAS_ROLL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RATE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_TILT       = 3'd5;

  localparam logic signed [19:0] GYRO_BIAS_X_RST      = 20'sd4343;
  localparam logic signed [19:0] GYRO_BIAS_Y_RST      = -20'sd5278;
  localparam logic signed [15:0] ANGLE_BIAS_PITCH_RST = 16'sd90;
  localparam logic signed [15:0] ANGLE_BIAS_ROLL_RST  = 16'sd185;
  localparam logic [15:0]        ALPHA_RATE_RST       = 16'd8897;
  localparam logic [15:0]        ALPHA_TILT_RST       = 16'd8897;

  // radians scale factors, gyro in Q.32 over Q.4 counts, angle in Q.22 over Q.6 degrees
  localparam logic signed [20:0] GYRO_K  = 21'sd571927;
  localparam logic signed [20:0] ANGLE_K = 21'sd73204;

  localparam int MUL_A_W = 22;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int WIDE_W  = 28;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_MUL_IN = 3'd0;
  localparam logic [OP_W-1:0] OP_SAT_IN = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL_SM = 3'd2;
  localparam logic [OP_W-1:0] OP_ACC_SM = 3'd3;
  localparam logic [OP_W-1:0] OP_DONE   = 3'd4;

  localparam logic [1:0] CH_GX = 2'd0;
  localparam logic [1:0] CH_GY = 2'd1;
  localparam logic [1:0] CH_AX = 2'd2;
  localparam logic [1:0] CH_AY = 2'd3;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_START = 5'd0;
  localparam logic [PC_W-1:0] PC_DONE  = 5'd16;

  typedef struct packed {
    logic              sample_due;
    logic              read_ok;
    logic signed [15:0] gyro_x_raw;
    logic signed [15:0] gyro_y_raw;
    logic signed [15:0] angle_pitch_deg;
    logic signed [15:0] angle_roll_deg;
  } sample_t;

  typedef struct packed {
    logic              stopped;
    logic signed [15:0] filt_gx;
    logic signed [15:0] filt_gy;
    logic signed [15:0] filt_ax;
    logic signed [15:0] filt_ay;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      ch;
    logic [PC_W-1:0] jmp;
  } ucode_t;

  // control store, jump taken on the load step while the first sample is pending
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      5'd0:    w = '{op: OP_MUL_IN, ch: CH_GX, jmp: 5'd0};
      5'd1:    w = '{op: OP_SAT_IN, ch: CH_GX, jmp: 5'd4};
      5'd2:    w = '{op: OP_MUL_SM, ch: CH_GX, jmp: 5'd0};
      5'd3:    w = '{op: OP_ACC_SM, ch: CH_GX, jmp: 5'd0};
      5'd4:    w = '{op: OP_MUL_IN, ch: CH_GY, jmp: 5'd0};
      5'd5:    w = '{op: OP_SAT_IN, ch: CH_GY, jmp: 5'd8};
      5'd6:    w = '{op: OP_MUL_SM, ch: CH_GY, jmp: 5'd0};
      5'd7:    w = '{op: OP_ACC_SM, ch: CH_GY, jmp: 5'd0};
      5'd8:    w = '{op: OP_MUL_IN, ch: CH_AX, jmp: 5'd0};
      5'd9:    w = '{op: OP_SAT_IN, ch: CH_AX, jmp: 5'd12};
      5'd10:   w = '{op: OP_MUL_SM, ch: CH_AX, jmp: 5'd0};
      5'd11:   w = '{op: OP_ACC_SM, ch: CH_AX, jmp: 5'd0};
      5'd12:   w = '{op: OP_MUL_IN, ch: CH_AY, jmp: 5'd0};
      5'd13:   w = '{op: OP_SAT_IN, ch: CH_AY, jmp: PC_DONE};
      5'd14:   w = '{op: OP_MUL_SM, ch: CH_AY, jmp: 5'd0};
      5'd15:   w = '{op: OP_ACC_SM, ch: CH_AY, jmp: 5'd0};
      default: w = '{op: OP_DONE,   ch: CH_GX, jmp: 5'd0};
    endcase
    return w;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [15:0] r;
    if (v > 28'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -28'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/imu_bias_scale_lowpass.sv
// ----------------------------------------------------------------------------
// imu_bias_scale_lowpass
// Gyro and tilt conditioning: bias removal, axis swap, scaling to radians in
// Q3.12 with saturation and a one-pole low-pass on each of four channels.
//
// Input items arrive on sample_valid / sample_stall / sample, results leave on
// result_valid / result_stall / result, one result per item. Registers are
// written through cfg_we / cfg_index / cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// An item with a good read runs a 17-step program on one shared multiplier
// (four steps per channel, the smoothing steps skipped on the first good
// sample, then one step to publish). An item with no sample due or a failed
// read takes one step, the publish step. sample_stall is high while an item
// is being worked on. If the receiver stalls, the result holds in the output
// register and the publish step waits for it to drain. Reset clears the
// filter state, marks the next good sample as the first and loads the
// register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_bias_scale_lowpass (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  ibsl_pkg::sample_t                 sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output ibsl_pkg::result_t                 result,
  input  logic                              cfg_we,
  input  logic [ibsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ibsl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ibsl_pkg::*;

  logic signed [19:0] gyro_bias_x;
  logic signed [19:0] gyro_bias_y;
  logic signed [15:0] angle_bias_pitch;
  logic signed [15:0] angle_bias_roll;
  logic [15:0]        alpha_rate;
  logic [15:0]        alpha_tilt;

  logic               busy;
  logic               first_sample;
  logic [PC_W-1:0]    pc;
  logic signed [15:0] held [4];

  sample_t            item;
  logic               full;
  logic               stopped;
  logic signed [15:0] x;
  logic signed [PROD_W-1:0] prod;

  ucode_t             uc;
  logic               accept;
  logic               out_free;
  logic               publish;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [WIDE_W-1:0]  in_scaled;
  logic signed [WIDE_W-1:0]  acc_sum;

  assign uc           = ucode_rom(pc);
  assign accept       = sample_valid && !busy;
  assign sample_stall = busy;
  assign out_free     = !result_valid || !result_stall;
  assign publish      = busy && uc.op == OP_DONE && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_bias_x      <= GYRO_BIAS_X_RST;
      gyro_bias_y      <= GYRO_BIAS_Y_RST;
      angle_bias_pitch <= ANGLE_BIAS_PITCH_RST;
      angle_bias_roll  <= ANGLE_BIAS_ROLL_RST;
      alpha_rate       <= ALPHA_RATE_RST;
      alpha_tilt       <= ALPHA_TILT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GYRO_BIAS_X:      gyro_bias_x      <= cfg_data;
        REG_GYRO_BIAS_Y:      gyro_bias_y      <= cfg_data;
        REG_ANGLE_BIAS_PITCH: angle_bias_pitch <= cfg_data[15:0];
        REG_ANGLE_BIAS_ROLL:  angle_bias_roll  <= cfg_data[15:0];
        REG_ALPHA_RATE:       alpha_rate       <= cfg_data[15:0];
        REG_ALPHA_TILT:       alpha_tilt       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands, negated axes folded into the subtraction order
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uc.op)
      OP_MUL_IN: begin
        unique case (uc.ch)
          CH_GX: begin
            mul_a = MUL_A_W'(gyro_bias_y) - (MUL_A_W'(item.gyro_y_raw) <<< 4);
            mul_b = GYRO_K;
          end
          CH_GY: begin
            mul_a = (MUL_A_W'(item.gyro_x_raw) <<< 4) - MUL_A_W'(gyro_bias_x);
            mul_b = GYRO_K;
          end
          CH_AX: begin
            mul_a = MUL_A_W'(item.angle_roll_deg) - MUL_A_W'(angle_bias_roll);
            mul_b = ANGLE_K;
          end
          default: begin
            mul_a = MUL_A_W'(angle_bias_pitch) - MUL_A_W'(item.angle_pitch_deg);
            mul_b = ANGLE_K;
          end
        endcase
      end
      OP_MUL_SM: begin
        mul_a = MUL_A_W'(x) - MUL_A_W'(held[uc.ch]);
        if (uc.ch == CH_GX || uc.ch == CH_GY) begin
          mul_b = $signed({5'b0, alpha_rate});
        end else begin
          mul_b = $signed({5'b0, alpha_tilt});
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (uc.ch == CH_GX || uc.ch == CH_GY) begin
      in_scaled = WIDE_W'($signed(prod[PROD_W-1:24]));
    end else begin
      in_scaled = WIDE_W'($signed(prod[PROD_W-1:16]));
    end
    acc_sum = WIDE_W'($signed(prod[PROD_W-1:16])) + WIDE_W'(held[uc.ch]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pc           <= PC_START;
      first_sample <= 1'b1;
      result_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        held[i] <= '0;
      end
    end else begin
      if (publish) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        pc   <= (sample.sample_due && sample.read_ok) ? PC_START : PC_DONE;
      end else if (busy) begin
        unique case (uc.op)
          OP_MUL_IN, OP_MUL_SM: pc <= pc + 1'b1;
          OP_SAT_IN: begin
            if (first_sample) begin
              held[uc.ch] <= sat16(in_scaled);
              pc          <= uc.jmp;
            end else begin
              pc <= pc + 1'b1;
            end
          end
          OP_ACC_SM: begin
            held[uc.ch] <= sat16(acc_sum);
            pc          <= pc + 1'b1;
          end
          default: begin
            if (out_free) begin
              busy <= 1'b0;
              if (full) begin
                first_sample <= 1'b0;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= sample;
      full    <= sample.sample_due && sample.read_ok;
      stopped <= sample.sample_due && !sample.read_ok;
    end
    if (busy) begin
      prod <= mul_a * mul_b;
    end
    if (busy && uc.op == OP_SAT_IN) begin
      x <= sat16(in_scaled);
    end
    if (publish) begin
      result.stopped <= stopped;
      result.filt_gx <= held[CH_GX];
      result.filt_gy <= held[CH_GY];
      result.filt_ax <= held[CH_AX];
      result.filt_ay <= held[CH_AY];
    end
  end

`ifndef NO_ASSERTIONS
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= PC_DONE)
    else $error("step counter beyond the program");

  a_first_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(first_sample) |-> $past(busy && full && uc.op == OP_DONE))
    else $error("first sample flag cleared outside a good item");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(busy && uc.op == OP_DONE))
    else $error("result raised outside the publish step");
`endif

endmodule

`default_nettype wire

FILE: test/ibsl_result_checker.sv
// ----------------------------------------------------------------------------
// ibsl_result_checker
// Watches the sample, result and register ports of the bias, scale and
// low-pass block. Keeps its own copy of the registers and filter state,
// works out the expected result of every accepted item, and compares each
// accepted result field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ibsl_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  input  logic                            sample_stall,
  input  ibsl_pkg::sample_t               sample,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  ibsl_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [ibsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ibsl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              outstanding
);

  import ibsl_pkg::*;

  localparam longint RATE_GAIN = 571927;
  localparam longint TILT_GAIN = 73204;

  result_t            expected_results[$];
  result_t            want;
  logic signed [19:0] bias_gx_q4;
  logic signed [19:0] bias_gy_q4;
  logic signed [15:0] bias_pitch_q6;
  logic signed [15:0] bias_roll_q6;
  logic [15:0]        alpha_rate_q16;
  logic [15:0]        alpha_tilt_q16;
  logic               awaiting_first;
  logic signed [15:0] held_gx;
  logic signed [15:0] held_gy;
  logic signed [15:0] held_ax;
  logic signed [15:0] held_ay;

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] smooth_toward(input logic signed [15:0] y,
                                                       input logic signed [15:0] x,
                                                       input logic [15:0] alpha);
    longint d;
    d = longint'(x) - longint'(y);
    return clamp16(longint'(y) + ((d * longint'(alpha)) >>> 16));
  endfunction

  // updates the held channels and returns the result of one item
  function automatic result_t filter_sample(input sample_t s);
    longint             d_gx;
    longint             d_gy;
    longint             d_ax;
    longint             d_ay;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    result_t            r;
    r.stopped = 1'b0;
    if (s.sample_due) begin
      if (!s.read_ok) begin
        r.stopped = 1'b1;
      end else begin
        d_gx = -(longint'($signed(s.gyro_y_raw)) * 16 - longint'(bias_gy_q4));
        d_gy = longint'($signed(s.gyro_x_raw)) * 16 - longint'(bias_gx_q4);
        d_ax = longint'($signed(s.angle_roll_deg)) - longint'(bias_roll_q6);
        d_ay = -(longint'($signed(s.angle_pitch_deg)) - longint'(bias_pitch_q6));
        gx = clamp16((d_gx * RATE_GAIN) >>> 24);
        gy = clamp16((d_gy * RATE_GAIN) >>> 24);
        ax = clamp16((d_ax * TILT_GAIN) >>> 16);
        ay = clamp16((d_ay * TILT_GAIN) >>> 16);
        if (awaiting_first) begin
          awaiting_first = 1'b0;
          held_gx = gx;
          held_gy = gy;
          held_ax = ax;
          held_ay = ay;
        end else begin
          held_gx = smooth_toward(held_gx, gx, alpha_rate_q16);
          held_gy = smooth_toward(held_gy, gy, alpha_rate_q16);
          held_ax = smooth_toward(held_ax, ax, alpha_tilt_q16);
          held_ay = smooth_toward(held_ay, ay, alpha_tilt_q16);
        end
      end
    end
    r.filt_gx = held_gx;
    r.filt_gy = held_gy;
    r.filt_ax = held_ax;
    r.filt_ay = held_ay;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      bias_gx_q4     = GYRO_BIAS_X_RST;
      bias_gy_q4     = GYRO_BIAS_Y_RST;
      bias_pitch_q6  = ANGLE_BIAS_PITCH_RST;
      bias_roll_q6   = ANGLE_BIAS_ROLL_RST;
      alpha_rate_q16 = ALPHA_RATE_RST;
      alpha_tilt_q16 = ALPHA_TILT_RST;
      awaiting_first = 1'b1;
      held_gx        = '0;
      held_gy        = '0;
      held_ax        = '0;
      held_ay        = '0;
      expected_results.delete();
      outstanding    = 0;
      fail_count     = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GYRO_BIAS_X:      bias_gx_q4     = cfg_data;
          REG_GYRO_BIAS_Y:      bias_gy_q4     = cfg_data;
          REG_ANGLE_BIAS_PITCH: bias_pitch_q6  = cfg_data[15:0];
          REG_ANGLE_BIAS_ROLL:  bias_roll_q6   = cfg_data[15:0];
          REG_ALPHA_RATE:       alpha_rate_q16 = cfg_data[15:0];
          REG_ALPHA_TILT:       alpha_tilt_q16 = cfg_data[15:0];
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        expected_results.push_back(filter_sample(sample));
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: stopped %0b gx %0d gy %0d ax %0d ay %0d",
                     result.stopped, result.filt_gx, result.filt_gy,
                     result.filt_ax, result.filt_ay);
          end
        end else begin
          want = expected_results.pop_front();
          if (result.stopped !== want.stopped || result.filt_gx !== want.filt_gx ||
              result.filt_gy !== want.filt_gy || result.filt_ax !== want.filt_ax ||
              result.filt_ay !== want.filt_ay) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at %0t: expected stopped %0b gx %0d gy %0d ax %0d ay %0d",
                       $realtime, want.stopped, want.filt_gx, want.filt_gy,
                       want.filt_ax, want.filt_ay);
              $display("  got stopped %0b gx %0d gy %0d ax %0d ay %0d",
                       result.stopped, result.filt_gx, result.filt_gy,
                       result.filt_ax, result.filt_ay);
            end
          end
        end
      end
      outstanding = expected_results.size();
    end
  end

endmodule

FILE: test/imu_bias_scale_lowpass_test.sv
// ----------------------------------------------------------------------------
// imu_bias_scale_lowpass_test
// Drives the bias, scale and low-pass block with directed corner items and
// then random items over several register settings and idling patterns,
// including a long output hold-off and pauses that drain the block. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_bias_scale_lowpass_test;

  import ibsl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 160;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    outstanding;
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int                    hold_cycles = 0;

  imu_bias_scale_lowpass DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ibsl_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver: long hold-off when asked, random stalls otherwise
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        result_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic sample_t make_sample(input logic due, input logic ok,
                                          input logic [15:0] gx, input logic [15:0] gy,
                                          input logic [15:0] pitch, input logic [15:0] roll);
    sample_t s;
    s.sample_due      = due;
    s.read_ok         = ok;
    s.gyro_x_raw      = gx;
    s.gyro_y_raw      = gy;
    s.angle_pitch_deg = pitch;
    s.angle_roll_deg  = roll;
    return s;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample();
    int kind;
    kind = $urandom_range(99);
    if (kind < 12) begin
      return make_sample(1'b0, 1'($urandom_range(1)), pick_word(), pick_word(),
                         pick_word(), pick_word());
    end
    return make_sample(1'b1, kind >= 24, pick_word(), pick_word(), pick_word(), pick_word());
  endfunction

  task automatic offer_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic drain_block();
    sample_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // 16-bit registers get junk in the unused upper bits
  task automatic load_settings(input logic [19:0] bgx, input logic [19:0] bgy,
                               input logic [15:0] bp, input logic [15:0] br,
                               input logic [15:0] ar, input logic [15:0] at);
    write_reg(REG_GYRO_BIAS_X, bgx);
    write_reg(REG_GYRO_BIAS_Y, bgy);
    write_reg(REG_ANGLE_BIAS_PITCH, {4'($urandom), bp});
    write_reg(REG_ANGLE_BIAS_ROLL, {4'($urandom), br});
    write_reg(REG_ALPHA_RATE, {4'($urandom), ar});
    write_reg(REG_ALPHA_TILT, {4'($urandom), at});
    write_reg(REG_SPARE_A, 20'($urandom));
    write_reg(REG_SPARE_B, 20'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner items on the reset settings
    offer_sample(make_sample(1'b0, 1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    offer_sample(make_sample(1'b1, 1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    offer_sample(make_sample(1'b1, 1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    offer_sample(make_sample(1'b1, 1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    offer_sample(make_sample(1'b1, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    offer_sample(make_sample(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    offer_sample(make_sample(1'b1, 1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    offer_sample(make_sample(1'b0, 1'b0, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    offer_sample(make_sample(1'b1, 1'b0, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
    offer_sample(make_sample(1'b1, 1'b1, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    offer_sample(make_sample(1'b1, 1'b1, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
    offer_sample(make_sample(1'b1, 1'b1, 16'h0001, 16'hffff, 16'h005a, 16'h00b9));

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain_block();
        case (phase)
          1: load_settings(20'h7ffff, 20'h7ffff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
          2: load_settings(20'h80000, 20'h80000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
          3: load_settings(20'h80000, 20'h7ffff, 16'h7fff, 16'h8000, 16'h0001, 16'h8000);
          default: load_settings(20'($urandom), 20'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom));
        endcase
      end
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      if (phase == 1) begin
        // saturation of the gyro channels with extreme biases
        offer_sample(make_sample(1'b1, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        offer_sample(make_sample(1'b1, 1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        offer_sample(make_sample(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      end
      if (phase == 4) begin
        hold_cycles = 400;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) begin
          drain_block();
        end
        offer_sample(random_sample());
      end
    end

    drain_block();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
